/* hw/rtl/fecc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fecc_pkg
// Shared types and constants for the per-flow ECN CE mark counter.
// ----------------------------------------------------------------------------
package fecc_pkg;

    localparam int TABLE_SETS = 1024;   // power of two
    localparam int TABLE_WAYS = 4;
    localparam int SET_W      = $clog2(TABLE_SETS);
    localparam int WAY_W      = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;

    localparam logic [1:0]  ECN_CE    = 2'b11;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [31:0] HASH_MULT = 32'h045D_9F3B;

    typedef enum logic [2:0] {
        ST_NOT_CE      = 3'd0,
        ST_OTHER_PROTO = 3'd1,
        ST_INSERTED    = 3'd2,
        ST_INCREMENTED = 3'd3,
        ST_SATURATED   = 3'd4,
        ST_FULL        = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_READ,
        S_UPDATE
    } state_t;

    // One way of a set: flow key and its mark count.
    typedef struct packed {
        logic [63:0] addrs;   // src_addr high, dst_addr low
        logic [31:0] ports;   // src_port high, dst_port low
        logic [7:0]  count;
    } entry_t;

    typedef entry_t [TABLE_WAYS-1:0] row_t;

endpackage

/* hw/rtl/fecc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fecc_if
// Valid/ready channels: packet header in, count result out.
// ----------------------------------------------------------------------------
interface fecc_pkt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tos;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;

    modport source (output valid, tos, protocol, src_addr, dst_addr, src_port, dst_port,
                    input ready);
    modport sink   (input valid, tos, protocol, src_addr, dst_addr, src_port, dst_port,
                    output ready);
endinterface

interface fecc_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] mark_count;

    modport source (output valid, status, mark_count, input ready);
    modport sink   (input valid, status, mark_count, output ready);
endinterface

/* hw/rtl/flow_ecn_ce_counter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_ecn_ce_counter_core
// Per-flow count of ECN CE marks in a set-associative flow table.
// ----------------------------------------------------------------------------
// Flow: the input transfer, then S_MUL, S_READ and S_UPDATE (hash, multiply,
//   read, update), then the result register; S_UPDATE waits while an untaken
//   result is held. One packet in flight, set by the set memory read-modify-write.
// Reset: control clears at once, then a pass over all TABLE_SETS (1024) sets
//   clears the valid memory one set per cycle; no input is taken during that pass.
// ----------------------------------------------------------------------------
module flow_ecn_ce_counter_core
    import fecc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    fecc_pkt_if.sink          pkt,
    fecc_res_if.source        res
);

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [SET_W-1:0]   clr_idx_reg, clr_idx_next;

    logic               in_xfer;     // input transfer this cycle
    logic               rd_en;       // read the set memories
    logic               upd;         // update stage retires the packet
    logic               clearing;

    // Packet registers (payload, no reset)
    logic               ce_reg;
    logic               proto_ok_reg;
    logic [63:0]        addrs_reg;
    logic [31:0]        ports_reg;
    logic [31:0]        mix_reg;     // key fold after first xor-shift
    logic [31:0]        prod_reg;    // after multiply
    logic [SET_W-1:0]   set_reg;

    // Result register
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [7:0]         out_count_reg;

    // ------------------------------------------------------------------
    // Memories: valid bits per set, and flow entries per set
    // ------------------------------------------------------------------
    logic [TABLE_WAYS-1:0] vld_mem [TABLE_SETS];
    row_t                  row_mem [TABLE_SETS];

    logic [TABLE_WAYS-1:0] vld_rd_reg;
    row_t                  row_rd_reg;

    logic                  vld_we;
    logic [SET_W-1:0]      vld_waddr;
    logic [TABLE_WAYS-1:0] vld_wdata;
    logic                  row_we;
    row_t                  row_wdata;

    // ------------------------------------------------------------------
    // Set index hash
    // ------------------------------------------------------------------
    logic [31:0]      key_fold;
    logic [31:0]      prod;
    logic [31:0]      hash_fin;
    logic [SET_W-1:0] set_idx;

    assign key_fold = pkt.src_addr ^ pkt.dst_addr ^ {pkt.src_port, pkt.dst_port};
    assign prod     = mix_reg * HASH_MULT;          // mod 2^32
    assign hash_fin = prod_reg ^ (prod_reg >> 16);
    assign set_idx  = hash_fin[SET_W-1:0];          // TABLE_SETS is a power of two

    // ------------------------------------------------------------------
    // State machine
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == {SET_W{1'b1}})
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (pkt.valid)
                    state_next = S_MUL;
            end
            S_MUL:    state_next = S_READ;
            S_READ:   state_next = S_UPDATE;
            S_UPDATE:
            begin
                if (upd)
                    state_next = S_IDLE;
            end
            default:  state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        clearing = 1'b0;
        rd_en    = 1'b0;
        upd      = 1'b0;
        pkt.ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:  clearing  = 1'b1;
            S_IDLE:   pkt.ready = 1'b1;
            S_MUL:    ;
            S_READ:   rd_en     = 1'b1;
            S_UPDATE: upd       = !out_valid_reg || res.ready;
            default:  ;
        endcase
    end

    assign in_xfer      = pkt.valid && pkt.ready;
    assign clr_idx_next = clr_idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (clearing)
                clr_idx_reg <= clr_idx_next;
        end
    end

    // ------------------------------------------------------------------
    // Packet pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ce_reg       <= (pkt.tos[1:0] == ECN_CE);
            proto_ok_reg <= (pkt.protocol == PROTO_TCP) || (pkt.protocol == PROTO_UDP);
            addrs_reg    <= {pkt.src_addr, pkt.dst_addr};
            ports_reg    <= {pkt.src_port, pkt.dst_port};
            mix_reg      <= key_fold ^ (key_fold >> 16);
        end
        if (state_reg == S_MUL)
            prod_reg <= prod;
        if (rd_en)
            set_reg <= set_idx;
    end

    // ------------------------------------------------------------------
    // Memory ports: one write, one registered read each
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (vld_we)
            vld_mem[vld_waddr] <= vld_wdata;
        if (rd_en)
            vld_rd_reg <= vld_mem[set_idx];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[set_reg] <= row_wdata;
        if (rd_en)
            row_rd_reg <= row_mem[set_idx];
    end

    // ------------------------------------------------------------------
    // Way match and update
    // ------------------------------------------------------------------
    logic [TABLE_WAYS-1:0] hit_vec;
    logic                  hit_any;
    logic                  free_any;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      free_way;
    entry_t                hit_entry;
    status_t               res_status;
    logic [7:0]            res_count;
    logic                  ins_we;
    logic                  inc_we;

    always_comb
    begin
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < TABLE_WAYS; w++)
        begin
            hit_vec[w] = vld_rd_reg[w]
                         && (row_rd_reg[w].addrs == addrs_reg)
                         && (row_rd_reg[w].ports == ports_reg);
        end
        // lowest matching way and lowest free way
        for (int w = TABLE_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
                hit_way = WAY_W'(w);
            if (!vld_rd_reg[w])
                free_way = WAY_W'(w);
        end
    end

    assign hit_any   = |hit_vec;
    assign free_any  = !(&vld_rd_reg);
    assign hit_entry = row_rd_reg[hit_way];

    always_comb
    begin
        res_status = ST_NOT_CE;
        res_count  = '0;
        ins_we     = 1'b0;
        inc_we     = 1'b0;
        if (!ce_reg)
            res_status = ST_NOT_CE;
        else if (!proto_ok_reg)
            res_status = ST_OTHER_PROTO;
        else if (hit_any)
        begin
            if (hit_entry.count == COUNT_MAX)
            begin
                res_status = ST_SATURATED;
                res_count  = COUNT_MAX;
            end
            else
            begin
                res_status = ST_INCREMENTED;
                res_count  = hit_entry.count + 8'd1;
                inc_we     = 1'b1;
            end
        end
        else if (free_any)
        begin
            res_status = ST_INSERTED;
            ins_we     = 1'b1;
        end
        else
            res_status = ST_FULL;
    end

    // Write-back row: the read row with the touched way replaced
    always_comb
    begin
        row_wdata = row_rd_reg;
        if (inc_we)
            row_wdata[hit_way].count = res_count;
        else
        begin
            row_wdata[free_way].addrs = addrs_reg;
            row_wdata[free_way].ports = ports_reg;
            row_wdata[free_way].count = '0;
        end
    end

    assign row_we = upd && (inc_we || ins_we);

    // Valid memory: cleared during the reset pass, set on insert
    always_comb
    begin
        vld_wdata = vld_rd_reg;
        vld_wdata[free_way] = 1'b1;
        if (clearing)
            vld_wdata = '0;
    end

    assign vld_we    = clearing || (upd && ins_we);
    assign vld_waddr = clearing ? clr_idx_reg : set_reg;

    // ------------------------------------------------------------------
    // Result register: holds a finished result until its transfer
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            out_status_reg <= res_status;
            out_count_reg  <= res_count;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.status     = out_status_reg;
    assign res.mark_count = out_count_reg;

endmodule
